// ===== hdl/tpi_pkg.sv =====
// tpi_pkg: shared types, constants and helpers of the turtle path interpreter.
// No dependencies; imported by tpi_dir and turtle_path_interpreter.
package tpi_pkg;

  localparam int SYM_W  = 8;
  localparam int HD_W   = 15;
  localparam int POS_W  = 32;
  localparam int SEG_W  = 16;
  localparam int DIR_W  = 17;
  localparam int UNIT_W = 16;
  localparam int QT_W   = 13;
  localparam int AGE_W  = 3;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // direction pipeline depth, heading register to dir output
  localparam int DIR_LAT = 4;

  localparam logic [HD_W-1:0] FULL_TURN     = 15'd23040;
  localparam logic [HD_W-1:0] THREE_QUARTER = 15'd17280;
  localparam logic [HD_W-1:0] HALF_TURN     = 15'd11520;
  localparam logic [HD_W-1:0] QUARTER_TURN  = 15'd5760;
  localparam logic [63:0]     HALF_PI_Q30   = 64'd1686629713;

  localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] SYM_PUSH  = 8'h5B;
  localparam logic [SYM_W-1:0] SYM_POP   = 8'h5D;

  typedef enum logic [2:0] {
    REG_STEP_ANGLE    = 3'd0,
    REG_SEG_LENGTH    = 3'd1,
    REG_START_X       = 3'd2,
    REG_START_Y       = 3'd3,
    REG_START_HEADING = 3'd4,
    REG_NULL_SYMBOL   = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    EX_IDLE,
    EX_RUN,
    EX_POP
  } ex_state_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [HD_W-1:0]         h;
  } stk_entry_t;

  typedef struct packed {
    logic signed [DIR_W-1:0] dx;
    logic signed [DIR_W-1:0] dy;
  } dir_t;

  function automatic logic signed [POS_W-1:0] sat_add(logic signed [POS_W-1:0] p,
                                                      logic signed [DIR_W-1:0] d);
    logic signed [POS_W:0] s;
    logic signed [POS_W-1:0] r;
    s = {p[POS_W-1], p} + {{(POS_W + 1 - DIR_W){d[DIR_W-1]}}, d};
    if (s[POS_W] != s[POS_W-1]) begin
      r = s[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      r = s[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/tpi_dir.sv =====
// tpi_dir: direction pipeline, heading -> quadrant and table index -> sine ROM ->
// scale by segment length -> rounded signed step. Depends on tpi_pkg.
module tpi_dir #(
  parameter int SINE_ENTRIES = 1024
) (
  input  logic                          clk,
  input  logic [tpi_pkg::HD_W-1:0]      heading,
  input  logic [tpi_pkg::SEG_W-1:0]     seg_length,
  output tpi_pkg::dir_t                 dir
);
  import tpi_pkg::*;

  localparam int IDX_W = $clog2(SINE_ENTRIES + 1);
  localparam int N_W   = $clog2(int'(QUARTER_TURN) * SINE_ENTRIES + 1);
  localparam int K_SH  = N_W + QT_W;
  localparam int P_W   = K_SH + IDX_W;
  localparam logic [63:0] RECIP =
    ((64'd1 << K_SH) + 64'(QUARTER_TURN) - 64'd1) / 64'(QUARTER_TURN);
  localparam logic [63:0] IDX_MUL = RECIP * 64'(SINE_ENTRIES);

  typedef logic [UNIT_W-1:0] sine_lut_t [SINE_ENTRIES+1];

  function automatic sine_lut_t build_sine_lut();
    sine_lut_t lut;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] r;
    longint sum;
    for (int i = 0; i <= SINE_ENTRIES; i++) begin
      x = (64'(i) * HALF_PI_Q30) / 64'(SINE_ENTRIES);
      term = x;
      sum = longint'(x);
      for (int k = 1; k <= 7; k++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      r = (64'(sum) + 64'd16384) >> 15;
      if (r > 64'd32768) begin
        r = 64'd32768;
      end
      lut[i] = UNIT_W'(r);
    end
    return lut;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine_lut();

  logic [1:0]        quad;
  logic [HD_W-1:0]   quad_base;
  logic [QT_W-1:0]   qa;
  logic [QT_W-1:0]   qb;
  logic [P_W-1:0]    pa;
  logic [P_W-1:0]    pb;

  logic [1:0]        s1_quad_r;
  logic [IDX_W-1:0]  s1_ia_r;
  logic [IDX_W-1:0]  s1_ib_r;
  logic [1:0]        s2_quad_r;
  logic [UNIT_W-1:0] s2_a_r;
  logic [UNIT_W-1:0] s2_b_r;

  logic [UNIT_W-1:0] cos_mag;
  logic [UNIT_W-1:0] sin_mag;
  logic              cos_neg;
  logic              sin_neg;

  logic [31:0]       s3_cm_r;
  logic [31:0]       s3_sm_r;
  logic              s3_cneg_r;
  logic              s3_sneg_r;

  logic [31:0]       c_rnd;
  logic [31:0]       s_rnd;
  logic [DIR_W-1:0]  c_abs;
  logic [DIR_W-1:0]  s_abs;
  dir_t              dir_r;

  always_comb begin
    if (heading >= THREE_QUARTER) begin
      quad = 2'd3;
      quad_base = THREE_QUARTER;
    end else if (heading >= HALF_TURN) begin
      quad = 2'd2;
      quad_base = HALF_TURN;
    end else if (heading >= QUARTER_TURN) begin
      quad = 2'd1;
      quad_base = QUARTER_TURN;
    end else begin
      quad = 2'd0;
      quad_base = '0;
    end
    qa = QT_W'(heading - quad_base);
    qb = QT_W'(QUARTER_TURN) - qa;
    pa = P_W'(qa) * P_W'(IDX_MUL);
    pb = P_W'(qb) * P_W'(IDX_MUL);
  end

  always_ff @(posedge clk) begin
    s1_quad_r <= quad;
    s1_ia_r   <= pa[K_SH +: IDX_W];
    s1_ib_r   <= pb[K_SH +: IDX_W];
  end

  // sine ROM, two registered reads
  always_ff @(posedge clk) begin
    s2_quad_r <= s1_quad_r;
    s2_a_r    <= SINE_LUT[s1_ia_r];
    s2_b_r    <= SINE_LUT[s1_ib_r];
  end

  always_comb begin
    case (s2_quad_r)
      2'd0: begin
        sin_mag = s2_a_r; sin_neg = 1'b0;
        cos_mag = s2_b_r; cos_neg = 1'b0;
      end
      2'd1: begin
        sin_mag = s2_b_r; sin_neg = 1'b0;
        cos_mag = s2_a_r; cos_neg = 1'b1;
      end
      2'd2: begin
        sin_mag = s2_a_r; sin_neg = 1'b1;
        cos_mag = s2_b_r; cos_neg = 1'b1;
      end
      default: begin
        sin_mag = s2_b_r; sin_neg = 1'b1;
        cos_mag = s2_a_r; cos_neg = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    s3_cm_r   <= 32'(cos_mag) * 32'(seg_length);
    s3_sm_r   <= 32'(sin_mag) * 32'(seg_length);
    s3_cneg_r <= cos_neg;
    s3_sneg_r <= sin_neg;
  end

  // round half away from zero at bit 15
  always_comb begin
    c_rnd = s3_cm_r + 32'd16384;
    s_rnd = s3_sm_r + 32'd16384;
    c_abs = DIR_W'(c_rnd >> 15);
    s_abs = DIR_W'(s_rnd >> 15);
  end

  always_ff @(posedge clk) begin
    dir_r.dx <= s3_cneg_r ? -signed'(c_abs) : signed'(c_abs);
    dir_r.dy <= s3_sneg_r ? -signed'(s_abs) : signed'(s_abs);
  end

  assign dir = dir_r;

endmodule

// ===== hdl/turtle_path_interpreter.sv =====
// turtle_path_interpreter: 2-D L-system turtle, one symbol per item, one result per item.
// Turns, pushes, nulls and moves finish in EX_RUN; a pop holds input until done in EX_POP.
// A move after a heading or length change waits until the 4-stage direction pipeline
// (index multiply, sine ROM, length multiply, rounding) has settled.
// Throughput: 1 item per cycle for runs of moves, turns, pushes while the output is free.
// Reset: synchronous, active low; position and heading 0, stack empty, registers default.
module turtle_path_interpreter #(
  parameter int STACK_DEPTH  = 32,
  parameter int SINE_ENTRIES = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [tpi_pkg::SYM_W-1:0]          in_symbol,
  input  logic                               in_first,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_draw,
  output logic signed [tpi_pkg::POS_W-1:0]   out_from_x,
  output logic signed [tpi_pkg::POS_W-1:0]   out_from_y,
  output logic signed [tpi_pkg::POS_W-1:0]   out_to_x,
  output logic signed [tpi_pkg::POS_W-1:0]   out_to_y,
  output logic [1:0]                         out_status,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [tpi_pkg::ADDR_W-1:0]         paddr,
  input  logic [tpi_pkg::DATA_W-1:0]         pwdata,
  output logic [tpi_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);
  import tpi_pkg::*;

  localparam int FILL_W = $clog2(STACK_DEPTH + 1);
  localparam int SA_W   = $clog2(STACK_DEPTH);
  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(STACK_DEPTH);

  // configuration
  logic [HD_W-1:0]         step_angle_r;
  logic [SEG_W-1:0]        seg_length_r;
  logic signed [POS_W-1:0] start_x_r;
  logic signed [POS_W-1:0] start_y_r;
  logic [HD_W-1:0]         start_hd_r;
  logic [SYM_W-1:0]        null_sym_r;
  reg_idx_t                cfg_idx;
  logic                    cfg_we;
  logic                    seg_we;

  // turtle state
  ex_state_t               st_r, st_nxt;
  logic [SYM_W-1:0]        ex_sym_r, ex_sym_nxt;
  logic                    ex_first_r, ex_first_nxt;
  logic signed [POS_W-1:0] pos_x_r, pos_x_nxt;
  logic signed [POS_W-1:0] pos_y_r, pos_y_nxt;
  logic [HD_W-1:0]         hd_r, hd_nxt;
  logic [FILL_W-1:0]       fill_r, fill_nxt;
  logic [AGE_W-1:0]        age_r, age_nxt;

  // stack memory
  stk_entry_t              stk_mem [STACK_DEPTH];
  stk_entry_t              stk_rd_r;
  stk_entry_t              stk_wr;
  logic                    stk_we;
  logic                    stk_re;
  logic [SA_W-1:0]         stk_wa;
  logic [SA_W-1:0]         stk_ra;

  // result register
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_draw_r;
  logic signed [POS_W-1:0] out_from_x_r;
  logic signed [POS_W-1:0] out_from_y_r;
  logic signed [POS_W-1:0] out_to_x_r;
  logic signed [POS_W-1:0] out_to_y_r;
  logic [1:0]              out_status_r;

  dir_t                    dir;
  logic [HD_W-1:0]         turn_amt;
  logic [HD_W-1:0]         start_hd;
  logic signed [POS_W-1:0] base_x;
  logic signed [POS_W-1:0] base_y;
  logic [HD_W-1:0]         base_h;
  logic [FILL_W-1:0]       base_fill;
  logic [HD_W-1:0]         hd_plus;
  logic [HD_W:0]           hd_sum;
  logic [HD_W-1:0]         hd_minus;
  logic signed [POS_W-1:0] mv_x;
  logic signed [POS_W-1:0] mv_y;
  logic                    is_plus, is_minus, is_push, is_pop, is_move;
  logic                    out_free;
  logic                    dir_ok;
  logic                    ex_done;
  logic                    pop_issue;
  logic                    in_take;
  logic                    res_draw;
  status_t                 res_status;
  logic signed [POS_W-1:0] res_from_x;
  logic signed [POS_W-1:0] res_from_y;

  // ---------------- configuration port ----------------
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_we  = psel && penable && pwrite;
  assign seg_we  = cfg_we && (cfg_idx == REG_SEG_LENGTH);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_angle_r <= 15'd1920;
      seg_length_r <= 16'd2560;
      start_x_r    <= '0;
      start_y_r    <= '0;
      start_hd_r   <= 15'd5760;
      null_sym_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_STEP_ANGLE:    step_angle_r <= pwdata[HD_W-1:0];
        REG_SEG_LENGTH:    seg_length_r <= pwdata[SEG_W-1:0];
        REG_START_X:       start_x_r    <= pwdata;
        REG_START_Y:       start_y_r    <= pwdata;
        REG_START_HEADING: start_hd_r   <= pwdata[HD_W-1:0];
        REG_NULL_SYMBOL:   null_sym_r   <= pwdata[SYM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_STEP_ANGLE:    prdata = DATA_W'(step_angle_r);
      REG_SEG_LENGTH:    prdata = DATA_W'(seg_length_r);
      REG_START_X:       prdata = start_x_r;
      REG_START_Y:       prdata = start_y_r;
      REG_START_HEADING: prdata = DATA_W'(start_hd_r);
      REG_NULL_SYMBOL:   prdata = DATA_W'(null_sym_r);
      default:           prdata = '0;
    endcase
  end

  // ---------------- direction pipeline ----------------
  tpi_dir #(
    .SINE_ENTRIES (SINE_ENTRIES)
  ) u_dir (
    .clk        (clk),
    .heading    (hd_r),
    .seg_length (seg_length_r),
    .dir        (dir)
  );

  // ---------------- datapath ----------------
  always_comb begin
    turn_amt  = (step_angle_r >= FULL_TURN) ? step_angle_r - FULL_TURN : step_angle_r;
    start_hd  = (start_hd_r >= FULL_TURN) ? start_hd_r - FULL_TURN : start_hd_r;
    base_x    = ex_first_r ? start_x_r : pos_x_r;
    base_y    = ex_first_r ? start_y_r : pos_y_r;
    base_h    = ex_first_r ? start_hd : hd_r;
    base_fill = ex_first_r ? '0 : fill_r;
    hd_plus   = (base_h >= turn_amt) ? base_h - turn_amt : base_h + (FULL_TURN - turn_amt);
    hd_sum    = {1'b0, base_h} + {1'b0, turn_amt};
    hd_minus  = (hd_sum >= {1'b0, FULL_TURN}) ? HD_W'(hd_sum - {1'b0, FULL_TURN})
                                              : hd_sum[HD_W-1:0];
    mv_x      = sat_add(base_x, dir.dx);
    mv_y      = sat_add(base_y, dir.dy);
    is_plus   = (ex_sym_r == SYM_PLUS);
    is_minus  = (ex_sym_r == SYM_MINUS);
    is_push   = (ex_sym_r == SYM_PUSH);
    is_pop    = (ex_sym_r == SYM_POP);
    is_move   = !is_plus && !is_minus && !is_push && !is_pop && (ex_sym_r != null_sym_r);
    out_free  = !out_valid_r || out_ready;
    dir_ok    = (age_r == AGE_W'(DIR_LAT)) && (base_h == hd_r);
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      EX_IDLE: begin
        if (in_take) st_nxt = EX_RUN;
      end
      EX_RUN: begin
        if (pop_issue) begin
          st_nxt = EX_POP;
        end else if (ex_done) begin
          st_nxt = in_take ? EX_RUN : EX_IDLE;
        end
      end
      EX_POP: begin
        if (ex_done) st_nxt = in_take ? EX_RUN : EX_IDLE;
      end
      default: st_nxt = EX_IDLE;
    endcase
  end

  // state updates and results
  always_comb begin
    pos_x_nxt    = pos_x_r;
    pos_y_nxt    = pos_y_r;
    hd_nxt       = hd_r;
    fill_nxt     = fill_r;
    ex_sym_nxt   = ex_sym_r;
    ex_first_nxt = ex_first_r;
    ex_done      = 1'b0;
    pop_issue    = 1'b0;
    res_draw     = 1'b0;
    res_status   = ST_OK;
    stk_we       = 1'b0;
    stk_re       = 1'b0;
    stk_wa       = SA_W'(base_fill);
    stk_ra       = SA_W'(base_fill - FILL_W'(1));
    stk_wr.x     = base_x;
    stk_wr.y     = base_y;
    stk_wr.h     = base_h;
    case (st_r)
      EX_RUN: begin
        // a pending reload is committed even while the symbol waits
        pos_x_nxt    = base_x;
        pos_y_nxt    = base_y;
        hd_nxt       = base_h;
        fill_nxt     = base_fill;
        ex_first_nxt = 1'b0;
        pop_issue    = is_pop && (base_fill != '0);
        stk_re       = pop_issue;
        ex_done      = out_free && !pop_issue && (!is_move || dir_ok);
        if (ex_done) begin
          if (is_plus) begin
            hd_nxt = hd_plus;
          end else if (is_minus) begin
            hd_nxt = hd_minus;
          end else if (is_push) begin
            if (base_fill == FULL_FILL) begin
              res_status = ST_OVERFLOW;
            end else begin
              stk_we   = 1'b1;
              fill_nxt = base_fill + FILL_W'(1);
            end
          end else if (is_pop) begin
            res_status = ST_UNDERFLOW;
          end else if (is_move) begin
            pos_x_nxt = mv_x;
            pos_y_nxt = mv_y;
            res_draw  = 1'b1;
          end
        end
      end
      EX_POP: begin
        ex_done = out_free;
        if (ex_done) begin
          pos_x_nxt = stk_rd_r.x;
          pos_y_nxt = stk_rd_r.y;
          hd_nxt    = stk_rd_r.h;
          fill_nxt  = fill_r - FILL_W'(1);
        end
      end
      default: ;
    endcase
    in_ready = (st_r == EX_IDLE) || ex_done;
    in_take  = in_valid && in_ready;
    if (in_take) begin
      ex_sym_nxt   = in_symbol;
      ex_first_nxt = in_first;
    end
    res_from_x    = res_draw ? base_x : pos_x_nxt;
    res_from_y    = res_draw ? base_y : pos_y_nxt;
    out_valid_nxt = ex_done || (out_valid_r && !out_ready);
    if ((hd_nxt != hd_r) || seg_we) begin
      age_nxt = '0;
    end else if (age_r == AGE_W'(DIR_LAT)) begin
      age_nxt = age_r;
    end else begin
      age_nxt = age_r + AGE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= EX_IDLE;
      ex_first_r  <= 1'b0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      hd_r        <= '0;
      fill_r      <= '0;
      age_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      ex_first_r  <= ex_first_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      hd_r        <= hd_nxt;
      fill_r      <= fill_nxt;
      age_r       <= age_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ex_sym_r <= ex_sym_nxt;
    if (ex_done) begin
      out_draw_r   <= res_draw;
      out_from_x_r <= res_from_x;
      out_from_y_r <= res_from_y;
      out_to_x_r   <= pos_x_nxt;
      out_to_y_r   <= pos_y_nxt;
      out_status_r <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wr;
    if (stk_re) stk_rd_r <= stk_mem[stk_ra];
  end

  assign out_valid  = out_valid_r;
  assign out_draw   = out_draw_r;
  assign out_from_x = out_from_x_r;
  assign out_from_y = out_from_y_r;
  assign out_to_x   = out_to_x_r;
  assign out_to_y   = out_to_y_r;
  assign out_status = out_status_r;

`ifndef ASSERT_OFF
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == EX_POP) |-> (fill_r != '0 && fill_r <= FULL_FILL))
    else $error("pop pending with empty or overfull stack");

  a_dir_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (hd_r != $past(hd_r)) |-> (age_r == '0))
    else $error("direction cache not restarted on heading change");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    ex_done |=> out_valid_r)
    else $error("completed item did not reach the output register");
`endif

endmodule
